FILE: design/apps_pkg.sv
// shared types and constants of the atapi pio packet sequencer
// no dependencies
package apps_pkg;

    localparam int unsigned POLL_RESET   = 32'd20000000;
    localparam logic [7:0]  DEVSEL_RESET = 8'hA0;
    localparam logic [7:0]  ST_ERR       = 8'h01;
    localparam logic [7:0]  ST_DRQ       = 8'h08;
    localparam logic [7:0]  ST_BSY       = 8'h80;
    localparam logic [7:0]  CMD_PACKET   = 8'hA0;

    localparam logic [3:0] R_DATA = 4'd0;
    localparam logic [3:0] R_FEAT = 4'd1;
    localparam logic [3:0] R_MID  = 4'd4;
    localparam logic [3:0] R_HIGH = 4'd5;
    localparam logic [3:0] R_DEV  = 4'd6;
    localparam logic [3:0] R_STAT = 4'd7;
    localparam logic [3:0] R_CTRL = 4'd8;

    localparam logic [1:0] K_READ  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_DATA  = 2'd2;
    localparam logic [1:0] K_DONE  = 2'd3;

    localparam logic [2:0] OC_OK      = 3'd0;
    localparam logic [2:0] OC_TIMEOUT = 3'd1;
    localparam logic [2:0] OC_DEVERR  = 3'd2;
    localparam logic [2:0] OC_NODRQ   = 3'd3;
    localparam logic [2:0] OC_SHORT   = 3'd4;

    localparam logic CFG_POLL_LIMIT = 1'b0;
    localparam logic CFG_DEVSEL     = 1'b1;

    typedef enum logic [4:0] {
        P_IDLE, P_WA, P_SEL, P_SET1, P_WB, P_FEAT, P_LMID, P_LHIGH, P_CMD, P_SET2,
        P_WC, P_CHKC, P_CW, P_SET3, P_WD, P_CHKD, P_WE, P_CHKE, P_CNTLO, P_CNTHI,
        P_DATA
    } phase_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] cdb_low;
        logic [31:0] cdb_high;
        logic [15:0] byte_limit;
        logic [15:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  reg_select;
        logic [15:0] write_data;
        logic        word_access;
        logic [15:0] data_word;
        logic [2:0]  outcome;
        logic        last;
    } out_item_t;

    // up to two results produced for one transaction, with their count
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } result_pair_t;

endpackage

FILE: design/apps_if.sv
// valid/ready channel interfaces for input and result transactions
// depends on apps_pkg
interface apps_in_if;
    import apps_pkg::*;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] cdb_low;
    logic [31:0] cdb_high;
    logic [15:0] byte_limit;
    logic [15:0] read_data;
    modport source (output valid, mode, cdb_low, cdb_high, byte_limit, read_data,
                    input ready);
    modport sink (input valid, mode, cdb_low, cdb_high, byte_limit, read_data,
                  output ready);
endinterface

interface apps_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  reg_select;
    logic [15:0] write_data;
    logic        word_access;
    logic [15:0] data_word;
    logic [2:0]  outcome;
    logic        last;
    modport source (output valid, kind, reg_select, write_data, word_access, data_word,
                    outcome, last, input ready);
    modport sink (input valid, kind, reg_select, write_data, word_access, data_word,
                  outcome, last, output ready);
endinterface

FILE: design/apps_front.sv
// front part: sequencer state machine, one transaction per cycle while in_fire is high, yields result pairs
// depends on apps_pkg
module apps_front #(
    parameter int COMMAND_WORDS = 6,
    parameter int SETTLE_READS  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  apps_pkg::in_item_t    in_item,
    input  logic [31:0]           poll_limit,
    input  logic [7:0]            device_select,
    output apps_pkg::result_pair_t pair
);
    import apps_pkg::*;

    localparam int CW_W = $clog2(COMMAND_WORDS);
    localparam int ST_W = (SETTLE_READS > 1) ? $clog2(SETTLE_READS) : 1;
    localparam int SC_W = (CW_W > ST_W) ? CW_W : ST_W;

    phase_t      phase_reg, phase_next;
    logic [31:0] poll_reg, poll_next;
    logic [15:0] limit_reg, limit_next;
    logic [14:0] wanted_reg, wanted_next;
    logic [15:0] recv_reg, recv_next;
    logic [14:0] pwords_reg, pwords_next;
    logic [14:0] pidx_reg, pidx_next;
    logic [SC_W-1:0] step_reg, step_next;
    logic [15:0] cw_reg [6];
    logic [15:0] cw_sel;

    logic [7:0]  st;
    logic [31:0] lim;
    logic [31:0] poll_inc;
    logic        bsy;
    logic [1:0]  n;
    out_item_t   r0, r1;
    logic [SC_W-1:0] step_inc;
    logic [15:0] cnt_full;

    function automatic out_item_t mk(logic [1:0] k, logic [3:0] r, logic [15:0] wd,
                                     logic wa, logic [15:0] dw, logic [2:0] oc);
        out_item_t o;
        o.kind = k;
        o.reg_select = r;
        o.write_data = wd;
        o.word_access = wa;
        o.data_word = dw;
        o.outcome = oc;
        o.last = 1'b0;
        return o;
    endfunction

    assign st       = in_item.read_data[7:0];
    assign lim      = (poll_limit == 32'd0) ? 32'd1 : poll_limit;
    assign poll_inc = poll_reg + 32'd1;
    assign bsy      = (st & ST_BSY) != 8'd0;
    assign step_inc = step_reg + SC_W'(1);
    assign cnt_full = {st, pwords_reg[7:0]};

    always_comb
    begin
        cw_sel = 16'd0;
        if (32'(step_inc) < 32'd6)
        begin
            cw_sel = cw_reg[3'(step_inc)];
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        poll_next   = poll_reg;
        limit_next  = limit_reg;
        wanted_next = wanted_reg;
        recv_next   = recv_reg;
        pwords_next = pwords_reg;
        pidx_next   = pidx_reg;
        step_next   = step_reg;
        n  = 2'd0;
        r0 = mk(K_READ, R_STAT, 16'd0, 1'b0, 16'd0, OC_OK);
        r1 = r0;
        if (in_fire)
        begin
            if (!in_item.mode)
            begin
                limit_next  = in_item.byte_limit;
                wanted_next = in_item.byte_limit[15:1];
                recv_next   = 16'd0;
                pwords_next = 15'd0;
                pidx_next   = 15'd0;
                step_next   = '0;
                poll_next   = 32'd0;
                phase_next  = P_WA;
                n = 2'd1;
            end
            else
            begin
                case (phase_reg)
                    P_WA, P_WB, P_WC, P_WD, P_WE:
                    begin
                        n = 2'd1;
                        if (bsy)
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= lim)
                            begin
                                r0 = mk(K_DONE, 4'd0, 16'd0, 1'b0, 16'd0, OC_TIMEOUT);
                                phase_next = P_IDLE;
                            end
                        end
                        else
                        begin
                            case (phase_reg)
                                P_WA:
                                begin
                                    phase_next = P_SEL;
                                    r0 = mk(K_WRITE, R_DEV, {8'd0, device_select}, 1'b0,
                                            16'd0, OC_OK);
                                end
                                P_WB:
                                begin
                                    phase_next = P_FEAT;
                                    r0 = mk(K_WRITE, R_FEAT, 16'd0, 1'b0, 16'd0, OC_OK);
                                end
                                P_WC: phase_next = P_CHKC;
                                P_WD: phase_next = P_CHKD;
                                default: phase_next = P_CHKE;
                            endcase
                        end
                    end
                    P_SEL, P_CMD:
                    begin
                        n = 2'd1;
                        phase_next = (phase_reg == P_SEL) ? P_SET1 : P_SET2;
                        step_next = '0;
                        r0 = mk(K_READ, R_CTRL, 16'd0, 1'b0, 16'd0, OC_OK);
                    end
                    P_SET1, P_SET2, P_SET3:
                    begin
                        n = 2'd1;
                        if (32'(step_reg) + 32'd1 >= 32'(SETTLE_READS))
                        begin
                            poll_next = 32'd0;
                            case (phase_reg)
                                P_SET1: phase_next = P_WB;
                                P_SET2: phase_next = P_WC;
                                default: phase_next = (limit_reg == 16'd0) ? P_WD : P_WE;
                            endcase
                        end
                        else
                        begin
                            step_next = step_inc;
                            r0 = mk(K_READ, R_CTRL, 16'd0, 1'b0, 16'd0, OC_OK);
                        end
                    end
                    P_FEAT:
                    begin
                        n = 2'd1;
                        phase_next = P_LMID;
                        r0 = mk(K_WRITE, R_MID, {8'd0, limit_reg[7:0]}, 1'b0, 16'd0, OC_OK);
                    end
                    P_LMID:
                    begin
                        n = 2'd1;
                        phase_next = P_LHIGH;
                        r0 = mk(K_WRITE, R_HIGH, {8'd0, limit_reg[15:8]}, 1'b0, 16'd0, OC_OK);
                    end
                    P_LHIGH:
                    begin
                        n = 2'd1;
                        phase_next = P_CMD;
                        r0 = mk(K_WRITE, R_STAT, {8'd0, CMD_PACKET}, 1'b0, 16'd0, OC_OK);
                    end
                    P_CHKC:
                    begin
                        n = 2'd1;
                        if ((st & ST_ERR) != 8'd0)
                        begin
                            r0 = mk(K_DONE, 4'd0, 16'd0, 1'b0, 16'd0, OC_DEVERR);
                            phase_next = P_IDLE;
                        end
                        else if ((st & ST_DRQ) == 8'd0)
                        begin
                            r0 = mk(K_DONE, 4'd0, 16'd0, 1'b0, 16'd0, OC_NODRQ);
                            phase_next = P_IDLE;
                        end
                        else
                        begin
                            phase_next = P_CW;
                            step_next = '0;
                            r0 = mk(K_WRITE, R_DATA, cw_reg[0], 1'b1, 16'd0, OC_OK);
                        end
                    end
                    P_CW:
                    begin
                        n = 2'd1;
                        if (32'(step_reg) + 32'd1 >= 32'(COMMAND_WORDS))
                        begin
                            phase_next = P_SET3;
                            step_next = '0;
                            r0 = mk(K_READ, R_CTRL, 16'd0, 1'b0, 16'd0, OC_OK);
                        end
                        else
                        begin
                            step_next = step_inc;
                            r0 = mk(K_WRITE, R_DATA, cw_sel, 1'b1, 16'd0, OC_OK);
                        end
                    end
                    P_CHKD:
                    begin
                        n = 2'd1;
                        phase_next = P_IDLE;
                        r0 = mk(K_DONE, 4'd0, 16'd0, 1'b0, 16'd0,
                                ((st & ST_ERR) != 8'd0) ? OC_DEVERR : OC_OK);
                    end
                    P_CHKE:
                    begin
                        n = 2'd1;
                        if ((st & ST_ERR) != 8'd0)
                        begin
                            r0 = mk(K_DONE, 4'd0, 16'd0, 1'b0, 16'd0, OC_DEVERR);
                            phase_next = P_IDLE;
                        end
                        else if ((st & ST_DRQ) == 8'd0)
                        begin
                            r0 = mk(K_DONE, 4'd0, 16'd0, 1'b0, 16'd0,
                                    (recv_reg == {1'b0, wanted_reg}) ? OC_OK : OC_SHORT);
                            phase_next = P_IDLE;
                        end
                        else
                        begin
                            phase_next = P_CNTLO;
                            r0 = mk(K_READ, R_MID, 16'd0, 1'b0, 16'd0, OC_OK);
                        end
                    end
                    P_CNTLO:
                    begin
                        n = 2'd1;
                        pwords_next = {7'd0, st};
                        phase_next = P_CNTHI;
                        r0 = mk(K_READ, R_HIGH, 16'd0, 1'b0, 16'd0, OC_OK);
                    end
                    P_CNTHI:
                    begin
                        n = 2'd1;
                        pwords_next = cnt_full[15:1];
                        pidx_next = 15'd0;
                        if (cnt_full[15:1] == 15'd0)
                        begin
                            poll_next = 32'd0;
                            phase_next = P_WE;
                        end
                        else
                        begin
                            phase_next = P_DATA;
                            r0 = mk(K_READ, R_DATA, 16'd0, 1'b1, 16'd0, OC_OK);
                        end
                    end
                    P_DATA:
                    begin
                        pidx_next = pidx_reg + 15'd1;
                        if (recv_reg < {1'b0, wanted_reg})
                        begin
                            recv_next = recv_reg + 16'd1;
                            r0 = mk(K_DATA, 4'd0, 16'd0, 1'b0, in_item.read_data, OC_OK);
                            n = 2'd2;
                        end
                        else
                        begin
                            n = 2'd1;
                        end
                        if (pidx_next >= pwords_reg)
                        begin
                            poll_next = 32'd0;
                            phase_next = P_WE;
                            r1 = mk(K_READ, R_STAT, 16'd0, 1'b0, 16'd0, OC_OK);
                        end
                        else
                        begin
                            r1 = mk(K_READ, R_DATA, 16'd0, 1'b1, 16'd0, OC_OK);
                        end
                        if (n == 2'd1)
                        begin
                            r0 = r1;
                        end
                    end
                    default:
                    begin
                        n = 2'd0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        pair.count  = n;
        pair.first  = r0;
        pair.second = r1;
        if (n == 2'd1)
        begin
            pair.first.last = 1'b1;
        end
        else
        begin
            pair.second.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= P_IDLE;
            poll_reg   <= 32'd0;
            limit_reg  <= 16'd0;
            wanted_reg <= 15'd0;
            recv_reg   <= 16'd0;
            pwords_reg <= 15'd0;
            pidx_reg   <= 15'd0;
            step_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            poll_reg   <= poll_next;
            limit_reg  <= limit_next;
            wanted_reg <= wanted_next;
            recv_reg   <= recv_next;
            pwords_reg <= pwords_next;
            pidx_reg   <= pidx_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !in_item.mode)
        begin
            cw_reg[0] <= in_item.cdb_low[15:0];
            cw_reg[1] <= in_item.cdb_low[31:16];
            cw_reg[2] <= in_item.cdb_low[47:32];
            cw_reg[3] <= in_item.cdb_low[63:48];
            cw_reg[4] <= in_item.cdb_high[15:0];
            cw_reg[5] <= in_item.cdb_high[31:16];
        end
    end

endmodule

FILE: design/apps_back.sv
// back part: result queue that drains one result transaction per cycle while out_ready is high
// depends on apps_pkg
module apps_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  apps_pkg::result_pair_t pair,
    output logic                   has_room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output apps_pkg::out_item_t    out_item
);
    import apps_pkg::*;

    localparam int DEPTH = 4;

    out_item_t  mem_reg [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = cnt_reg != 3'd0;
    assign out_item  = mem_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    assign has_room  = cnt_reg <= 3'd2;
    assign cnt_next  = cnt_reg + {1'b0, pair.count} - {2'd0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wp_reg  <= wp_reg + pair.count;
            rp_reg  <= rp_reg + {1'b0, pop};
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair.count != 2'd0)
        begin
            mem_reg[wp_reg] <= pair.first;
        end
        if (pair.count == 2'd2)
        begin
            mem_reg[wp_reg + 2'd1] <= pair.second;
        end
    end

endmodule

FILE: design/atapi_pio_packet_sequencer.sv
// top level of the atapi pio packet sequencer: config registers, front and back parts
// depends on apps_pkg, apps_if, apps_front, apps_back
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        mode, cdb_low, cdb_high, byte_limit, read_data
//  out_ch    out  valid/ready        kind, reg_select, write_data, word_access, ...
//  cfg       in   cfg_we, cfg_index  cfg_data (32 bits)
//
// one transaction is taken per cycle while the result queue has room for two results
// results are written into the queue registers and leave it one per cycle while out_ready is high
// the four-entry result queue sets the stall point; ready drops once fewer than two
// entries are free, a pop in the same cycle is not counted
// reset clears the sequencer to idle and empties the queue
module atapi_pio_packet_sequencer #(
    parameter int COMMAND_WORDS = 6,
    parameter int SETTLE_READS  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    apps_in_if.sink     in_ch,
    apps_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import apps_pkg::*;

    logic [31:0]  poll_limit_reg;
    logic [7:0]   devsel_reg;
    logic         in_fire;
    logic         has_room;
    in_item_t     in_item;
    out_item_t    out_item;
    result_pair_t pair;

    assign in_ch.ready = has_room;
    assign in_fire = in_ch.valid && has_room;
    assign in_item.mode = in_ch.mode;
    assign in_item.cdb_low = in_ch.cdb_low;
    assign in_item.cdb_high = in_ch.cdb_high;
    assign in_item.byte_limit = in_ch.byte_limit;
    assign in_item.read_data = in_ch.read_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= POLL_RESET;
            devsel_reg     <= DEVSEL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_POLL_LIMIT)
            begin
                poll_limit_reg <= cfg_data;
            end
            else
            begin
                devsel_reg <= cfg_data[7:0];
            end
        end
    end

    apps_front #(
        .COMMAND_WORDS(COMMAND_WORDS),
        .SETTLE_READS (SETTLE_READS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .in_item      (in_item),
        .poll_limit   (poll_limit_reg),
        .device_select(devsel_reg),
        .pair         (pair)
    );

    apps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair     (pair),
        .has_room (has_room),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .out_item (out_item)
    );

    assign out_ch.kind        = out_item.kind;
    assign out_ch.reg_select  = out_item.reg_select;
    assign out_ch.write_data  = out_item.write_data;
    assign out_ch.word_access = out_item.word_access;
    assign out_ch.data_word   = out_item.data_word;
    assign out_ch.outcome     = out_item.outcome;
    assign out_ch.last        = out_item.last;

endmodule

FILE: bench/tb_pkg.sv
`timescale 1ns / 100ps
// sequencer state type and result helper used by the bench to predict the result stream
// depends on apps_pkg
package tb_pkg;
    import apps_pkg::*;

    typedef struct {
        phase_t      ph;
        logic [31:0] polls;
        logic [15:0] cw [6];
        logic [15:0] lim;
        logic [14:0] wanted;
        logic [15:0] got;
        logic [14:0] pwords;
        logic [14:0] pidx;
        logic [2:0]  step;
        logic [31:0] poll_limit;
        logic [7:0]  devsel;
    } seq_state_t;

    function automatic out_item_t mk(logic [1:0] k, logic [3:0] r, logic [15:0] wd,
                                     logic wa, logic [15:0] dw, logic [2:0] oc);
        out_item_t o;
        o.kind = k;
        o.reg_select = r;
        o.write_data = wd;
        o.word_access = wa;
        o.data_word = dw;
        o.outcome = oc;
        o.last = 1'b0;
        return o;
    endfunction
endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// bench for the atapi pio packet sequencer: a modeled device answers each bus access
// depends on apps_pkg, apps_if, tb_pkg and the sequencer rtl
module tb_top;
    import apps_pkg::*;
    import tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    int          errors = 0;
    int          idle_cycles = 0;
    int          hold_off = 0;
    int          items_sent = 0;
    bit          rx_gaps = 1'b1;

    apps_in_if  in_ch();
    apps_out_if out_ch();

    atapi_pio_packet_sequencer DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    seq_state_t  seq;
    out_item_t   expected_results [$];
    out_item_t   last_access;
    int          step_results;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.cdb_low = '0;
        in_ch.cdb_high = '0;
        in_ch.byte_limit = '0;
        in_ch.read_data = '0;
        out_ch.ready = 1'b0;
    end

    task automatic put(out_item_t o);
        if (step_results < 2)
        begin
            expected_results.push_back(o);
            step_results++;
        end
    endtask

    task automatic fin(logic [2:0] oc);
        put(mk(K_DONE, 4'd0, 16'd0, 1'b0, 16'd0, oc));
        seq.ph = P_IDLE;
    endtask

    task automatic begin_wait(phase_t p);
        seq.polls = 0;
        seq.ph = p;
        put(mk(K_READ, R_STAT, 16'd0, 1'b0, 16'd0, OC_OK));
    endtask

    task automatic poll_done(logic [7:0] st, output bit done);
        logic [31:0] lim;
        lim = (seq.poll_limit == 0) ? 32'd1 : seq.poll_limit;
        done = (st & ST_BSY) == 0;
        if (!done)
        begin
            seq.polls++;
            if (seq.polls >= lim)
                fin(OC_TIMEOUT);
            else
                put(mk(K_READ, R_STAT, 16'd0, 1'b0, 16'd0, OC_OK));
        end
    endtask

    task automatic begin_settle(phase_t p);
        seq.ph = p;
        seq.step = 0;
        put(mk(K_READ, R_CTRL, 16'd0, 1'b0, 16'd0, OC_OK));
    endtask

    task automatic settle_done(output bit done);
        done = (seq.step + 1 >= 4);
        if (!done)
        begin
            seq.step = seq.step + 3'd1;
            put(mk(K_READ, R_CTRL, 16'd0, 1'b0, 16'd0, OC_OK));
        end
    endtask

    function automatic logic [15:0] cmd_word(logic [2:0] i);
        return (i < 6) ? seq.cw[i] : 16'd0;
    endfunction

    task automatic predict_sequencer(in_item_t it);
        logic [7:0] st;
        bit d;
        int first;
        st = it.read_data[7:0];
        step_results = 0;
        first = expected_results.size();
        if (it.mode == 1'b0)
        begin
            for (int k = 0; k < 4; k++)
                seq.cw[k] = it.cdb_low[16*k +: 16];
            seq.cw[4] = it.cdb_high[15:0];
            seq.cw[5] = it.cdb_high[31:16];
            seq.lim = it.byte_limit;
            seq.wanted = it.byte_limit[15:1];
            seq.got = 0;
            seq.pwords = 0;
            seq.pidx = 0;
            seq.step = 0;
            begin_wait(P_WA);
        end
        else
        begin
            case (seq.ph)
                P_WA:
                begin
                    poll_done(st, d);
                    if (d)
                    begin
                        seq.ph = P_SEL;
                        put(mk(K_WRITE, R_DEV, {8'd0, seq.devsel}, 1'b0, 16'd0, OC_OK));
                    end
                end
                P_SEL: begin_settle(P_SET1);
                P_SET1:
                begin
                    settle_done(d);
                    if (d)
                        begin_wait(P_WB);
                end
                P_WB:
                begin
                    poll_done(st, d);
                    if (d)
                    begin
                        seq.ph = P_FEAT;
                        put(mk(K_WRITE, R_FEAT, 16'd0, 1'b0, 16'd0, OC_OK));
                    end
                end
                P_FEAT:
                begin
                    seq.ph = P_LMID;
                    put(mk(K_WRITE, R_MID, {8'd0, seq.lim[7:0]}, 1'b0, 16'd0, OC_OK));
                end
                P_LMID:
                begin
                    seq.ph = P_LHIGH;
                    put(mk(K_WRITE, R_HIGH, {8'd0, seq.lim[15:8]}, 1'b0, 16'd0, OC_OK));
                end
                P_LHIGH:
                begin
                    seq.ph = P_CMD;
                    put(mk(K_WRITE, R_STAT, {8'd0, CMD_PACKET}, 1'b0, 16'd0, OC_OK));
                end
                P_CMD: begin_settle(P_SET2);
                P_SET2:
                begin
                    settle_done(d);
                    if (d)
                        begin_wait(P_WC);
                end
                P_WC, P_WD, P_WE:
                begin
                    poll_done(st, d);
                    if (d)
                    begin
                        seq.ph = (seq.ph == P_WC) ? P_CHKC : (seq.ph == P_WD) ? P_CHKD : P_CHKE;
                        put(mk(K_READ, R_STAT, 16'd0, 1'b0, 16'd0, OC_OK));
                    end
                end
                P_CHKC:
                begin
                    if (st & ST_ERR)
                        fin(OC_DEVERR);
                    else if ((st & ST_DRQ) == 0)
                        fin(OC_NODRQ);
                    else
                    begin
                        seq.ph = P_CW;
                        seq.step = 0;
                        put(mk(K_WRITE, R_DATA, cmd_word(0), 1'b1, 16'd0, OC_OK));
                    end
                end
                P_CW:
                begin
                    if (seq.step + 1 >= 6)
                        begin_settle(P_SET3);
                    else
                    begin
                        seq.step = seq.step + 3'd1;
                        put(mk(K_WRITE, R_DATA, cmd_word(seq.step), 1'b1, 16'd0, OC_OK));
                    end
                end
                P_SET3:
                begin
                    settle_done(d);
                    if (d)
                        begin_wait(seq.lim == 0 ? P_WD : P_WE);
                end
                P_CHKD: fin((st & ST_ERR) ? OC_DEVERR : OC_OK);
                P_CHKE:
                begin
                    if (st & ST_ERR)
                        fin(OC_DEVERR);
                    else if ((st & ST_DRQ) == 0)
                        fin((seq.got == {1'b0, seq.wanted}) ? OC_OK : OC_SHORT);
                    else
                    begin
                        seq.ph = P_CNTLO;
                        put(mk(K_READ, R_MID, 16'd0, 1'b0, 16'd0, OC_OK));
                    end
                end
                P_CNTLO:
                begin
                    seq.pwords = {7'd0, st};
                    seq.ph = P_CNTHI;
                    put(mk(K_READ, R_HIGH, 16'd0, 1'b0, 16'd0, OC_OK));
                end
                P_CNTHI:
                begin
                    seq.pwords = {st, seq.pwords[7:0]} >> 1;
                    seq.pidx = 0;
                    if (seq.pwords == 0)
                        begin_wait(P_WE);
                    else
                    begin
                        seq.ph = P_DATA;
                        put(mk(K_READ, R_DATA, 16'd0, 1'b1, 16'd0, OC_OK));
                    end
                end
                P_DATA:
                begin
                    if (seq.got < {1'b0, seq.wanted})
                    begin
                        put(mk(K_DATA, 4'd0, 16'd0, 1'b0, it.read_data, OC_OK));
                        seq.got++;
                    end
                    seq.pidx++;
                    if (seq.pidx >= seq.pwords)
                        begin_wait(P_WE);
                    else
                        put(mk(K_READ, R_DATA, 16'd0, 1'b1, 16'd0, OC_OK));
                end
                default: ;
            endcase
        end
        if (expected_results.size() > first)
            expected_results[$].last = 1'b1;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_item(in_item_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= it.mode;
        in_ch.cdb_low <= it.cdb_low;
        in_ch.cdb_high <= it.cdb_high;
        in_ch.byte_limit <= it.byte_limit;
        in_ch.read_data <= it.read_data;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_sequencer(it);
        items_sent++;
    endtask

    task automatic write_reg(logic idx, logic [31:0] v);
        in_ch.valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POLL_LIMIT)
            seq.poll_limit = v;
        else
            seq.devsel = v[7:0];
        @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    // an access answered by a status value or data
    task automatic respond(logic [15:0] rd);
        in_item_t it;
        it = '0;
        it.mode = 1'b1;
        it.read_data = rd;
        it.cdb_low = {$urandom, $urandom};
        it.cdb_high = $urandom;
        it.byte_limit = $urandom;
        send_item(it);
    endtask

    task automatic start_cmd(logic [15:0] lim);
        in_item_t it;
        it.mode = 1'b0;
        it.cdb_low = {$urandom, $urandom};
        it.cdb_high = $urandom;
        it.byte_limit = lim;
        it.read_data = $urandom;
        send_item(it);
    endtask

    function automatic logic [15:0] status_val(int busy_pct, int err_pct, int drq_pct);
        logic [7:0] s;
        s = $urandom;
        s[7] = ($urandom_range(0, 99) < busy_pct);
        s[0] = ($urandom_range(0, 99) < err_pct);
        s[3] = ($urandom_range(0, 99) < drq_pct);
        return {$urandom_range(0, 255), s};
    endfunction

    // answers according to the access the model expects next, which mirrors the bus
    task automatic device_answer(int busy_pct, int err_pct, logic [7:0] cnt_lo,
                                 logic [7:0] cnt_hi, int drq_pct);
        logic [15:0] rd;
        case (seq.ph)
            P_WA, P_WB, P_WC, P_WD, P_WE: rd = status_val(busy_pct, 0, 0);
            P_CHKC, P_CHKD: rd = status_val(0, err_pct, 95);
            P_CHKE: rd = status_val(0, err_pct, drq_pct);
            P_CNTLO: rd = {$urandom_range(0, 255), cnt_lo};
            P_CNTHI: rd = {$urandom_range(0, 255), cnt_hi};
            default: rd = $urandom;
        endcase
        respond(rd);
    endtask

    task automatic run_command(logic [15:0] lim, int busy_pct, int err_pct, int max_items);
        int n;
        logic [7:0] lo;
        logic [7:0] hi;
        n = 0;
        start_cmd(lim);
        while (seq.ph != P_IDLE && n < max_items)
        begin
            lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 13);
            hi = ($urandom_range(0, 9) == 0) ? 8'd0 + $urandom_range(0, 1) : 8'd0;
            device_answer(busy_pct, err_pct, lo, hi, 60);
            n++;
        end
    endtask

    task automatic test_directed();
        in_item_t it;
        it = '0;
        it.mode = 1'b1;
        it.read_data = 16'hFFFF;
        send_item(it);
        write_reg(CFG_POLL_LIMIT, 32'd0);
        write_reg(CFG_DEVSEL, 32'd255);
        start_cmd(16'hFFFF);
        respond(16'h0080);
        drain();
        write_reg(CFG_POLL_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_DEVSEL, 32'd0);
        run_command(16'd0, 30, 0, 200);
        run_command(16'd7, 10, 0, 200);
        start_cmd(16'd4);
        respond(16'h0000);
        respond(16'h0000);
        start_cmd(16'd3);
        repeat (12)
            device_answer(0, 0, 8'd3, 8'd0, 100);
        drain();
    endtask

    task automatic test_configs();
        write_reg(CFG_POLL_LIMIT, 32'd1);
        write_reg(CFG_DEVSEL, DEVSEL_RESET);
        repeat (4)
            run_command($urandom_range(0, 20), 40, 10, 200);
        drain();
        write_reg(CFG_POLL_LIMIT, 32'd3);
        write_reg(CFG_DEVSEL, $urandom_range(0, 255));
        repeat (6)
            run_command($urandom_range(0, 40), 50, 10, 200);
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_POLL_LIMIT, 32'd1000);
        hold_off = 60;
        run_command(16'd30, 0, 0, 80);
        drain();
    endtask

    task automatic test_random();
        int start_count;
        bit switched;
        logic [15:0] lim;
        lim = 16'd0;
        switched = 1'b0;
        write_reg(CFG_POLL_LIMIT, $urandom_range(2, 8));
        start_count = items_sent;
        while (items_sent - start_count < 1200)
        begin
            if (!switched && items_sent - start_count >= 600)
            begin
                switched = 1'b1;
                drain();
                write_reg(CFG_POLL_LIMIT, 32'd20);
                write_reg(CFG_DEVSEL, $urandom);
                rx_gaps = 1'b0;
            end
            case ($urandom_range(0, 9))
                0: respond($urandom);
                1: lim = $urandom;
                2: lim = 16'd0;
                default: lim = $urandom_range(1, 40);
            endcase
            run_command(lim, 25, 8, $urandom_range(0, 5) == 0 ? $urandom_range(1, 20) : 120);
            rx_gaps = (items_sent % 300) > 100;
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (rx_gaps)
            out_ch.ready <= (gap_len() == 0);
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with none expected");
                errors++;
            end
            else
            begin
                last_access = expected_results.pop_front();
                if (out_ch.kind !== last_access.kind)
                begin
                    $error("kind exp %0d got %0d", last_access.kind, out_ch.kind);
                    errors++;
                end
                if (out_ch.reg_select !== last_access.reg_select)
                begin
                    $error("reg_select exp %0d got %0d", last_access.reg_select,
                           out_ch.reg_select);
                    errors++;
                end
                if (out_ch.write_data !== last_access.write_data)
                begin
                    $error("write_data exp %h got %h", last_access.write_data,
                           out_ch.write_data);
                    errors++;
                end
                if (out_ch.word_access !== last_access.word_access)
                begin
                    $error("word_access exp %0d got %0d", last_access.word_access,
                           out_ch.word_access);
                    errors++;
                end
                if (out_ch.data_word !== last_access.data_word)
                begin
                    $error("data_word exp %h got %h", last_access.data_word, out_ch.data_word);
                    errors++;
                end
                if (out_ch.outcome !== last_access.outcome)
                begin
                    $error("outcome exp %0d got %0d", last_access.outcome, out_ch.outcome);
                    errors++;
                end
                if (out_ch.last !== last_access.last)
                begin
                    $error("last exp %0d got %0d", last_access.last, out_ch.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        seq = '{ph: P_IDLE, polls: 0, cw: '{default: 16'd0}, lim: 0, wanted: 0, got: 0,
                pwords: 0, pidx: 0, step: 0, poll_limit: POLL_RESET, devsel: DEVSEL_RESET};
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_configs();
        test_backpressure();
        test_random();
        if (errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
